// ===== rtl/core/bzcp_pkg.sv =====
// Shared types and constants for the bandpass zero-crossing phase detector.
// Used by the controller, the datapath and the top level.
package bzcp_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_FILTER_GAIN  = 3'd0;
   localparam logic [2:0] REG_FEEDBACK_ONE = 3'd1;
   localparam logic [2:0] REG_FEEDBACK_TWO = 3'd2;
   localparam logic [2:0] REG_PHASE_STEP   = 3'd3;
   localparam logic [2:0] REG_WINDOW_LEN   = 3'd4;
   localparam logic [2:0] REG_RATIO_THRESH = 3'd5;

   localparam int SampleBits = 16;
   localparam int WinBits    = 13;
   localparam logic [WinBits-1:0] WinReset = 13'd1024;
   localparam logic [WinBits-1:0] WinMax   = 13'd4096;

   // datapath operation codes
   typedef logic [3:0] op_type;
   localparam op_type OP_NONE      = 4'd0;
   localparam op_type OP_LOAD      = 4'd1;
   localparam op_type OP_MUL_B0X   = 4'd2;
   localparam op_type OP_Y         = 4'd3;
   localparam op_type OP_MUL_F1Y   = 4'd4;
   localparam op_type OP_D0        = 4'd5;
   localparam op_type OP_D1        = 4'd6;
   localparam op_type OP_UPD       = 4'd7;
   localparam op_type OP_MUL_TR    = 4'd8;
   localparam op_type OP_CHECK     = 4'd9;
   localparam op_type OP_DIV_STEP  = 4'd10;
   localparam op_type OP_MUL_QS    = 4'd11;
   localparam op_type OP_OUT_ACT   = 4'd12;
   localparam op_type OP_OUT_INACT = 4'd13;

   typedef struct packed {
      op_type op;
      logic   sec;   // filter section in use
   } cmd_type;

   typedef struct packed {
      logic win_end;
      logic seen;
      logic ok;
   } status_type;

   typedef struct packed {
      logic signed [31:0]  filter_gain;
      logic signed [31:0]  feedback_one;
      logic signed [31:0]  feedback_two;
      logic [31:0]         phase_step;
      logic [WinBits-1:0]  window_length;
      logic [15:0]         ratio_threshold;
   } cfg_type;

endpackage

// ===== rtl/core/bzcp_ctrl.sv =====
// Sequencer for the bandpass zero-crossing phase detector.
// Depends on bzcp_pkg; drives bzcp_dpath through command and status structs.
module bzcp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  bzcp_pkg::status_type status,
   output bzcp_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MB0  = 4'd1;
   localparam logic [3:0] ST_Y    = 4'd2;
   localparam logic [3:0] ST_MF1  = 4'd3;
   localparam logic [3:0] ST_D0   = 4'd4;
   localparam logic [3:0] ST_D1   = 4'd5;
   localparam logic [3:0] ST_UPD  = 4'd6;
   localparam logic [3:0] ST_MTR  = 4'd7;
   localparam logic [3:0] ST_CHK  = 4'd8;
   localparam logic [3:0] ST_DIV  = 4'd9;
   localparam logic [3:0] ST_MQS  = 4'd10;
   localparam logic [3:0] ST_OUT  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       sec_ff, sec_in;
   logic [4:0] div_cnt_ff, div_cnt_in;
   logic       act_ff, act_in;
   logic       vld_ff, vld_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = vld_ff;

   // next state and command
   always_comb begin
      state_in   = state_ff;
      sec_in     = sec_ff;
      div_cnt_in = div_cnt_ff;
      act_in     = act_ff;
      vld_in     = vld_ff && !rsp_tready;
      cmd.sec    = sec_ff;
      cmd.op     = bzcp_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = bzcp_pkg::OP_LOAD;
               sec_in   = 1'b0;
               state_in = ST_MB0;
            end
         end
         ST_MB0: begin
            cmd.op   = bzcp_pkg::OP_MUL_B0X;
            state_in = ST_Y;
         end
         ST_Y: begin
            cmd.op   = bzcp_pkg::OP_Y;
            state_in = ST_MF1;
         end
         ST_MF1: begin
            cmd.op   = bzcp_pkg::OP_MUL_F1Y;
            state_in = ST_D0;
         end
         ST_D0: begin
            cmd.op   = bzcp_pkg::OP_D0;
            state_in = ST_D1;
         end
         ST_D1: begin
            cmd.op = bzcp_pkg::OP_D1;
            if (!sec_ff) begin
               sec_in   = 1'b1;
               state_in = ST_MB0;
            end else begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.op   = bzcp_pkg::OP_UPD;
            state_in = ST_MTR;
         end
         ST_MTR: begin
            cmd.op   = bzcp_pkg::OP_MUL_TR;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            priority if (!status.win_end) begin
               state_in = ST_IDLE;
            end else if (!status.seen) begin
               cmd.op   = bzcp_pkg::OP_CHECK;
               state_in = ST_IDLE;
            end else if (status.ok) begin
               cmd.op     = bzcp_pkg::OP_CHECK;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end else begin
               cmd.op   = bzcp_pkg::OP_CHECK;
               act_in   = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            cmd.op     = bzcp_pkg::OP_DIV_STEP;
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               state_in = ST_MQS;
            end
         end
         ST_MQS: begin
            cmd.op   = bzcp_pkg::OP_MUL_QS;
            act_in   = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!vld_ff || rsp_tready) begin
               cmd.op   = act_ff ? bzcp_pkg::OP_OUT_ACT : bzcp_pkg::OP_OUT_INACT;
               vld_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         sec_ff     <= 1'b0;
         div_cnt_ff <= '0;
         act_ff     <= 1'b0;
         vld_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sec_ff     <= sec_in;
         div_cnt_ff <= div_cnt_in;
         act_ff     <= act_in;
         vld_ff     <= vld_in;
      end
   end

endmodule

// ===== rtl/core/bzcp_dpath.sv =====
// Datapath: shared multiplier, two biquad sections, window sums,
// crossing capture, serial divider and result register. Depends on bzcp_pkg.
module bzcp_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  bzcp_pkg::cfg_type    cfg,
   input  bzcp_pkg::cmd_type    cmd,
   output bzcp_pkg::status_type status,
   input  logic [15:0]          sample,
   output logic [31:0]          phase,
   output logic                 active
);

   localparam logic signed [65:0] YMax = 66'sd2147483647;
   localparam logic signed [65:0] DMax = 66'sd140737488355327;
   localparam logic signed [65:0] Half = 66'sd536870912;

   function automatic logic signed [31:0] sat_y(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > YMax) r = 32'sd2147483647;
      else if (v < -YMax) r = -32'sd2147483647;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [47:0] sat_d(input logic signed [65:0] v);
      logic signed [47:0] r;
      if (v > DMax) r = DMax[47:0];
      else if (v < -DMax - 66'sd1) r = {1'b1, 47'd0};
      else r = v[47:0];
      return r;
   endfunction

   logic [15:0]         samp_ff;
   logic signed [31:0]  x_ff, y_ff, prev_ff, cb_ff, ca_ff;
   logic signed [63:0]  p_ff;
   logic signed [65:0]  prod_ff;
   logic signed [47:0]  d00_ff, d01_ff, d10_ff, d11_ff;
   logic [31:0]         raw_ff, filt_ff, cref_ff, ref_ff, q_ff;
   logic                seen_ff, win_end_ff;
   logic [12:0]         cnt_ff;
   logic [33:0]         rem_ff;
   logic [32:0]         den_ff;
   logic [31:0]         phase_ff;
   logic                active_ff;

   logic signed [32:0]  mul_a, mul_b;
   logic                mul_en;
   logic signed [47:0]  d0_sel, d1_sel;
   logic signed [65:0]  y_acc, n0_acc, n1_acc;
   logic [31:0]         y_abs;
   logic [16:0]         s_abs;
   logic [32:0]         raw_sum, filt_sum;
   logic [12:0]         cnt_next, win_len;
   logic [33:0]         div_t;
   logic [31:0]         cref_off;
   logic                ratio_ok;

   // operand select for the shared multiplier
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (cmd.op)
         bzcp_pkg::OP_MUL_B0X: begin
            mul_a = {cfg.filter_gain[31], cfg.filter_gain};
            mul_b = {x_ff[31], x_ff};
         end
         bzcp_pkg::OP_MUL_F1Y: begin
            mul_a = {cfg.feedback_one[31], cfg.feedback_one};
            mul_b = {y_ff[31], y_ff};
         end
         bzcp_pkg::OP_D0: begin
            mul_a = {cfg.feedback_two[31], cfg.feedback_two};
            mul_b = {y_ff[31], y_ff};
         end
         bzcp_pkg::OP_MUL_TR: begin
            mul_a = {17'd0, cfg.ratio_threshold};
            mul_b = {1'b0, raw_ff};
         end
         bzcp_pkg::OP_MUL_QS: begin
            mul_a = {1'b0, q_ff};
            mul_b = {1'b0, cfg.phase_step};
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // section arithmetic
   assign d0_sel = cmd.sec ? d10_ff : d00_ff;
   assign d1_sel = cmd.sec ? d11_ff : d01_ff;
   assign y_acc  = (prod_ff + $signed({{4{d0_sel[47]}}, d0_sel, 14'd0}) + Half) >>> 30;
   assign n0_acc = (prod_ff + $signed({{4{d1_sel[47]}}, d1_sel, 14'd0})) >>> 14;
   assign n1_acc = (prod_ff - $signed({{2{p_ff[63]}}, p_ff})) >>> 14;

   // window sums and count
   assign y_abs    = y_ff[31] ? (~y_ff + 32'd1) : y_ff;
   assign s_abs    = samp_ff[15] ? (17'd0 - {1'b1, samp_ff}) : {1'b0, samp_ff};
   assign raw_sum  = {1'b0, raw_ff} + {16'd0, s_abs};
   assign filt_sum = {1'b0, filt_ff} + {15'd0, y_abs[31:14]};
   assign cnt_next = cnt_ff + 13'd1;
   always_comb begin
      priority if (cfg.window_length == '0) win_len = 13'd1;
      else if (cfg.window_length > bzcp_pkg::WinMax) win_len = bzcp_pkg::WinMax;
      else win_len = cfg.window_length;
   end

   // ratio window test
   assign ratio_ok = (raw_ff != 32'd0)
                  && ({2'b0, filt_ff, 14'd0} > prod_ff[47:0])
                  && (({3'd0, filt_ff} * 35'd5) < ({3'd0, raw_ff} * 35'd7));
   assign status   = '{win_end: win_end_ff, seen: seen_ff, ok: ratio_ok};

   assign div_t    = {rem_ff[32:0], 1'b0};
   assign cref_off = cref_ff + prod_ff[63:32];

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d00_ff     <= '0;
         d01_ff     <= '0;
         d10_ff     <= '0;
         d11_ff     <= '0;
         prev_ff    <= '0;
         raw_ff     <= '0;
         filt_ff    <= '0;
         cb_ff      <= '0;
         ca_ff      <= '0;
         cref_ff    <= '0;
         seen_ff    <= 1'b0;
         cnt_ff     <= '0;
         ref_ff     <= '0;
         win_end_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            bzcp_pkg::OP_D0: begin
               if (cmd.sec) d10_ff <= sat_d(n0_acc);
               else d00_ff <= sat_d(n0_acc);
            end
            bzcp_pkg::OP_D1: begin
               if (cmd.sec) d11_ff <= sat_d(n1_acc);
               else d01_ff <= sat_d(n1_acc);
            end
            bzcp_pkg::OP_UPD: begin
               raw_ff  <= raw_sum[32] ? 32'hFFFF_FFFF : raw_sum[31:0];
               filt_ff <= filt_sum[32] ? 32'hFFFF_FFFF : filt_sum[31:0];
               if (prev_ff[31] && !y_ff[31] && (y_ff != 32'sd0)) begin
                  cb_ff   <= prev_ff;
                  ca_ff   <= y_ff;
                  cref_ff <= ref_ff;
                  seen_ff <= 1'b1;
               end
               prev_ff    <= y_ff;
               cnt_ff     <= cnt_next;
               win_end_ff <= (cnt_next >= win_len);
               ref_ff     <= ref_ff + cfg.phase_step;
            end
            bzcp_pkg::OP_CHECK: begin
               raw_ff  <= '0;
               filt_ff <= '0;
               cnt_ff  <= '0;
               seen_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         bzcp_pkg::OP_LOAD: begin
            samp_ff <= sample;
            x_ff    <= {{2{sample[15]}}, sample, 14'd0};
         end
         bzcp_pkg::OP_Y: begin
            p_ff <= prod_ff[63:0];
            y_ff <= sat_y(y_acc);
         end
         bzcp_pkg::OP_D1: begin
            x_ff <= y_ff;
         end
         bzcp_pkg::OP_CHECK: begin
            // start the crossing fraction division
            rem_ff <= {2'b0, ~cb_ff + 32'd1};
            den_ff <= {ca_ff[31], ca_ff} - {cb_ff[31], cb_ff};
            q_ff   <= '0;
         end
         bzcp_pkg::OP_DIV_STEP: begin
            if (div_t >= {1'b0, den_ff}) begin
               rem_ff <= div_t - {1'b0, den_ff};
               q_ff   <= {q_ff[30:0], 1'b1};
            end else begin
               rem_ff <= div_t;
               q_ff   <= {q_ff[30:0], 1'b0};
            end
         end
         bzcp_pkg::OP_OUT_ACT: begin
            phase_ff  <= 32'd0 - cref_off;
            active_ff <= 1'b1;
         end
         bzcp_pkg::OP_OUT_INACT: begin
            phase_ff  <= '0;
            active_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign phase  = phase_ff;
   assign active = active_ff;

endmodule

// ===== rtl/core/bandpass_zero_crossing_phase.sv =====
// Top level of the bandpass zero-crossing phase detector: configuration
// registers plus bzcp_ctrl and bzcp_dpath. Depends on bzcp_pkg.
//
//  channel | direction | word contents
//  req     | in        | tdata[15:0] sample
//  rsp     | out       | tdata[31:0] phase, tuser active
//  csr     | in        | csr_index selects register, csr_wdata value
//
// Each sample passes through one shared 33x33 multiplier in steps: a load,
// the product, output and delay steps of each filter section, then sums,
// ratio product and window check. A window closing with a crossing and a
// good ratio adds the bit-serial divider, the phase product and the result
// load; one with a crossing but a poor ratio adds the inactive result load.
// Reset is synchronous and clears all filter and window state.
// A result waiting on rsp stalls the block only when the next result is due.
module bandpass_zero_crossing_phase (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] phase
   output logic        rsp_tuser,   // [0] active
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   bzcp_pkg::cfg_type    cfg_ff;
   bzcp_pkg::cmd_type    cmd;
   bzcp_pkg::status_type status;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_gain     <= '0;
         cfg_ff.feedback_one    <= '0;
         cfg_ff.feedback_two    <= '0;
         cfg_ff.phase_step      <= '0;
         cfg_ff.window_length   <= bzcp_pkg::WinReset;
         cfg_ff.ratio_threshold <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            bzcp_pkg::REG_FILTER_GAIN:  cfg_ff.filter_gain  <= csr_wdata;
            bzcp_pkg::REG_FEEDBACK_ONE: cfg_ff.feedback_one <= csr_wdata;
            bzcp_pkg::REG_FEEDBACK_TWO: cfg_ff.feedback_two <= csr_wdata;
            bzcp_pkg::REG_PHASE_STEP:   cfg_ff.phase_step   <= csr_wdata;
            bzcp_pkg::REG_WINDOW_LEN: begin
               cfg_ff.window_length <= csr_wdata[bzcp_pkg::WinBits-1:0];
            end
            bzcp_pkg::REG_RATIO_THRESH: cfg_ff.ratio_threshold <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   bzcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bzcp_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .cmd    (cmd),
      .status (status),
      .sample (req_tdata),
      .phase  (rsp_tdata),
      .active (rsp_tuser)
   );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for bandpass_zero_crossing_phase: drives samples on req,
// predicts each phase word in SystemVerilog and checks every rsp word against it.
// Depends on bzcp_pkg and the bandpass_zero_crossing_phase RTL.
`timescale 1ns / 1ps

module testbench;

   localparam longint YMAX = 64'sd2147483647;
   localparam longint DMAX = 64'sd140737488355327;

   typedef struct packed {
      logic [31:0] phase;
      logic        active;
   } phase_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wen;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   bandpass_zero_crossing_phase uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the configuration registers
   logic signed [31:0] cfg_gain, cfg_fb1, cfg_fb2;
   logic [31:0]        cfg_step;
   logic [12:0]        cfg_win;
   logic [15:0]        cfg_thresh;

   // predicted detector state
   longint      stage_d [2][2];
   int          prev_y, cross_before, cross_after;
   logic [31:0] raw_sum, filt_sum, cross_ref, ref_phase;
   logic [12:0] win_count;
   bit          cross_seen;

   phase_word_type phase_words [$];
   int          mismatches;
   bit          idle_on;
   int          rsp_hold;
   int          rsp_gap;
   int          send_gap;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

   function automatic longint clamp64(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [31:0] sum_sat(logic [31:0] a, longint unsigned b);
      longint unsigned s;
      s = longint'(a) + b;
      return s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // one transposed direct form II bandpass section
   function automatic longint bp_section(longint x, int st);
      longint p, acc, y, n0, n1;
      p   = longint'(cfg_gain) * x;
      acc = p + stage_d[st][0] * 64'sd16384;
      y   = (acc + (64'sd1 <<< 29)) >>> 30;
      y   = clamp64(y, -YMAX, YMAX);
      n0  = (longint'(cfg_fb1) * y + stage_d[st][1] * 64'sd16384) >>> 14;
      n1  = (longint'(cfg_fb2) * y - p) >>> 14;
      stage_d[st][0] = clamp64(n0, -DMAX - 1, DMAX);
      stage_d[st][1] = clamp64(n1, -DMAX - 1, DMAX);
      return y;
   endfunction

   // advance the predicted state by one sample, queue a phase word if one is due
   function automatic void predict_phase(logic signed [15:0] smp);
      longint          sv, y;
      longint unsigned f, r, num, den, q, off;
      int unsigned     len;
      phase_word_type  w;
      sv = smp;
      y  = bp_section(sv * 64'sd16384, 0);
      y  = bp_section(y, 1);
      raw_sum  = sum_sat(raw_sum, sv < 0 ? -sv : sv);
      filt_sum = sum_sat(filt_sum, (y < 0 ? -y : y) >> 14);
      if (prev_y < 0 && y > 0) begin
         cross_before = prev_y;
         cross_after  = int'(y);
         cross_ref    = ref_phase;
         cross_seen   = 1'b1;
      end
      prev_y = int'(y);
      len = cfg_win;
      if (len == 0) len = 1;
      if (len > 4096) len = 4096;
      win_count = win_count + 13'd1;
      if (win_count >= len) begin
         if (cross_seen) begin
            f = filt_sum;
            r = raw_sum;
            if (r != 0 && (f << 14) > longint'(cfg_thresh) * r && 5 * f < 7 * r) begin
               num = -longint'(cross_before);
               den = longint'(cross_after) - longint'(cross_before);
               q   = den != 0 ? ((num << 32) / den) & 64'hFFFF_FFFF : 0;
               off = (q * longint'(cfg_step)) >> 32;
               w.phase  = 32'd0 - (cross_ref + off[31:0]);
               w.active = 1'b1;
            end else begin
               w.phase  = 32'd0;
               w.active = 1'b0;
            end
            phase_words = {phase_words, w};
            cross_seen = 1'b0;
         end
         win_count = 13'd0;
         raw_sum   = 32'd0;
         filt_sum  = 32'd0;
      end
      ref_phase = ref_phase + cfg_step;
   endfunction

   // check each accepted phase word against the oldest prediction
   always @(posedge clock) begin
      phase_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (phase_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: phase %h active %b", rsp_tdata, rsp_tuser);
         end else begin
            w = phase_words.pop_front();
            if (rsp_tdata !== w.phase || rsp_tuser !== w.active) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected phase %h active %b, got phase %h active %b",
                           w.phase, w.active, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   // receiver: long hold-off on request, otherwise random stall bursts while idle gaps are on
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= rsp_gap - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wen = 1'b0;
      case (idx)
         bzcp_pkg::REG_FILTER_GAIN:  cfg_gain   = val;
         bzcp_pkg::REG_FEEDBACK_ONE: cfg_fb1    = val;
         bzcp_pkg::REG_FEEDBACK_TWO: cfg_fb2    = val;
         bzcp_pkg::REG_PHASE_STEP:   cfg_step   = val;
         bzcp_pkg::REG_WINDOW_LEN:   cfg_win    = val[12:0];
         bzcp_pkg::REG_RATIO_THRESH: cfg_thresh = val[15:0];
         default: ;
      endcase
   endtask

   // offer one sample word and predict it once accepted
   task automatic send_sample(logic [15:0] smp);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         send_gap = $urandom_range(1, 4);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (send_gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = smp;
      do @(posedge clock); while (!req_tready);
      predict_phase(smp);
   endtask

   // drop valid, wait for every predicted word, then let the block go idle
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (phase_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [15:0] tone(real amp, real w, int n, int noise);
      real    v;
      longint iv;
      v  = amp * $sin(w * n);
      iv = longint'(v) + $signed($urandom_range(0, 2 * noise)) - noise;
      return 16'(clamp64(iv, -32768, 32767));
   endfunction

   // tuned bandpass near an eighth of pi
   task automatic load_design(int jitter);
      write_reg(bzcp_pkg::REG_FILTER_GAIN,
                32'sd52345000 + $signed($urandom_range(0, 2 * jitter)) - jitter);
      write_reg(bzcp_pkg::REG_FEEDBACK_ONE,
                32'sd1884821000 + $signed($urandom_range(0, 2 * jitter)) - jitter);
      write_reg(bzcp_pkg::REG_FEEDBACK_TWO,
                -32'sd969046000 + $signed($urandom_range(0, 2 * jitter)) - jitter);
   endtask

   task automatic test_directed();
      logic [15:0] edges [10];
      edges = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF,
                16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000};
      // default registers: filter output stays at zero
      repeat (4) send_sample(16'h7FFF);
      settle();
      load_design(0);
      write_reg(bzcp_pkg::REG_PHASE_STEP, 32'h1000_0000);
      write_reg(bzcp_pkg::REG_WINDOW_LEN, 32'd0);
      write_reg(bzcp_pkg::REG_RATIO_THRESH, 32'd0);
      foreach (edges[i]) send_sample(edges[i]);
      // zero input while the filter rings: raw sum zero
      repeat (8) send_sample(16'h0000);
      settle();
   endtask

   task automatic test_window_lengths();
      int n;
      load_design(0);
      write_reg(bzcp_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
      write_reg(bzcp_pkg::REG_RATIO_THRESH, 32'd2000);
      // above the maximum: a long window that stays open
      write_reg(bzcp_pkg::REG_WINDOW_LEN, 32'hFFFF_FFFF);
      for (n = 0; n < 300; n++) send_sample(tone(20000.0, 0.3927, n, 300));
      settle();
      // lower the length below the running count
      write_reg(bzcp_pkg::REG_WINDOW_LEN, 32'd2);
      for (n = 0; n < 40; n++) send_sample(tone(12000.0, 0.3927, n, 100));
      settle();
      write_reg(bzcp_pkg::REG_WINDOW_LEN, 32'd64);
      for (n = 0; n < 40; n++) send_sample(tone(12000.0, 0.3927, n, 100));
      settle();
      write_reg(bzcp_pkg::REG_WINDOW_LEN, 32'd8);
      for (n = 0; n < 20; n++) send_sample(tone(12000.0, 0.3927, n, 100));
      settle();
   endtask

   task automatic test_random_tones();
      int   ph, n, pick;
      real  amp, w;
      for (ph = 0; ph < 12; ph++) begin
         if (ph == 5) begin
            write_reg(bzcp_pkg::REG_FILTER_GAIN, 32'h8000_0000);
            write_reg(bzcp_pkg::REG_FEEDBACK_ONE, 32'h7FFF_FFFF);
            write_reg(bzcp_pkg::REG_FEEDBACK_TWO, $urandom());
         end else if (ph == 6) begin
            write_reg(bzcp_pkg::REG_FILTER_GAIN, 32'h7FFF_FFFF);
            write_reg(bzcp_pkg::REG_FEEDBACK_ONE, 32'h8000_0000);
            write_reg(bzcp_pkg::REG_FEEDBACK_TWO, 32'h7FFF_FFFF);
         end else begin
            load_design(ph * 2000000);
         end
         pick = $urandom_range(0, 3);
         write_reg(bzcp_pkg::REG_RATIO_THRESH, pick == 0 ? 32'd0 : pick == 1 ? 32'd65535 :
                   pick == 2 ? 32'd4000 : $urandom());
         write_reg(bzcp_pkg::REG_PHASE_STEP,
                   ph == 0 ? 32'd0 : ph == 1 ? 32'hFFFF_FFFF : $urandom());
         write_reg(bzcp_pkg::REG_WINDOW_LEN, ph == 2 ? 32'd1 : $urandom_range(1, 64));
         amp = $urandom_range(0, 32767);
         w   = 0.30 + $urandom_range(0, 200) / 1000.0;
         for (n = 0; n < 70; n++) begin
            if ($urandom_range(0, 3) == 0) send_sample(16'($urandom()));
            else send_sample(tone(amp, w, n, $urandom_range(0, 2000)));
         end
         settle();
      end
   endtask

   task automatic test_backpressure();
      int n;
      load_design(0);
      write_reg(bzcp_pkg::REG_WINDOW_LEN, 32'd1);
      write_reg(bzcp_pkg::REG_RATIO_THRESH, 32'd0);
      // hold the receiver off while samples keep coming
      @(negedge clock);
      rsp_hold = 400;
      for (n = 0; n < 80; n++) send_sample(16'($urandom()));
      settle();
   endtask

   task automatic test_no_idle();
      int n;
      idle_on = 1'b0;
      load_design(1000000);
      write_reg(bzcp_pkg::REG_WINDOW_LEN, 32'd4);
      write_reg(bzcp_pkg::REG_PHASE_STEP, $urandom());
      for (n = 0; n < 150; n++) send_sample(tone(25000.0, 0.3927, n, 500));
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 16'h0000;
      rsp_tready = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = bzcp_pkg::REG_FILTER_GAIN;
      csr_wdata  = 32'd0;
      rsp_hold   = 0;
      rsp_gap    = 0;
      mismatches = 0;
      idle_on    = 1'b1;
      cfg_gain = 0; cfg_fb1 = 0; cfg_fb2 = 0; cfg_step = 0;
      cfg_win = bzcp_pkg::WinReset; cfg_thresh = 0;
      stage_d = '{'{0, 0}, '{0, 0}};
      prev_y = 0; cross_before = 0; cross_after = 0;
      raw_sum = 0; filt_sum = 0; cross_ref = 0; ref_phase = 0;
      win_count = 0; cross_seen = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_window_lengths();
      test_random_tones();
      test_backpressure();
      test_no_idle();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (phase_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && phase_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
